### rtl/ttf_pkg.sv
`timescale 1ns / 1ps
package ttf_pkg;

  localparam int CW   = 32;
  localparam int FRAC = 16;
  localparam int DW   = CW + 1;
  localparam int PW   = 2 * DW;
  localparam int SW   = PW + 1;
  localparam int NW   = SW + FRAC + 2;
  localparam int QW   = CW + 1;
  localparam int RW   = SW + 1;
  localparam int NCOMP = 6;

  typedef logic signed [DW-1:0] dlt_t;

  typedef struct packed {
    dlt_t           du1;
    dlt_t           dv1;
    dlt_t           du2;
    dlt_t           dv2;
    dlt_t [2:0]     e1;
    dlt_t [2:0]     e2;
  } tri_job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_SUB,
    B_DIV0,
    B_DIV,
    B_RES,
    B_FIN
  } back_state_e;

endpackage

### rtl/ttf_front.sv
`timescale 1ns / 1ps
module ttf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ttf_pkg::CW-1:0]   pos_x_i,
  input  logic signed [ttf_pkg::CW-1:0]   pos_y_i,
  input  logic signed [ttf_pkg::CW-1:0]   pos_z_i,
  input  logic signed [ttf_pkg::CW-1:0]   tex_u_i,
  input  logic signed [ttf_pkg::CW-1:0]   tex_v_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output ttf_pkg::tri_job_t               push_data_o
);
  import ttf_pkg::*;

  logic [1:0]                 count_q, count_d;
  logic signed [CW-1:0]       p0_q [3];
  logic signed [CW-1:0]       p1_q [3];
  logic signed [CW-1:0]       uv0_q [2];
  logic signed [CW-1:0]       uv1_q [2];
  logic signed [CW-1:0]       p_in [3];
  logic                       acc;

  assign p_in[0] = pos_x_i;
  assign p_in[1] = pos_y_i;
  assign p_in[2] = pos_z_i;

  assign in_stall_o = (count_q == 2'd2) && q_full_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign push_o     = acc && (count_q == 2'd2);

  always_comb begin
    count_d = count_q;
    if (acc) begin
      case (count_q)
        2'd1:    count_d = 2'd2;
        2'd2:    count_d = 2'd0;
        default: count_d = 2'd1;
      endcase
    end
  end

  always_comb begin
    push_data_o.du1 = DW'(uv1_q[0]) - DW'(uv0_q[0]);
    push_data_o.dv1 = DW'(uv1_q[1]) - DW'(uv0_q[1]);
    push_data_o.du2 = DW'(tex_u_i) - DW'(uv0_q[0]);
    push_data_o.dv2 = DW'(tex_v_i) - DW'(uv0_q[1]);
    for (int i = 0; i < 3; i++) begin
      push_data_o.e1[i] = DW'(p1_q[i]) - DW'(p0_q[i]);
      push_data_o.e2[i] = DW'(p_in[i]) - DW'(p0_q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && count_q == 2'd1) begin
      for (int i = 0; i < 3; i++) p1_q[i] <= p_in[i];
      uv1_q[0] <= tex_u_i;
      uv1_q[1] <= tex_v_i;
    end else if (acc && count_q != 2'd2) begin
      for (int i = 0; i < 3; i++) p0_q[i] <= p_in[i];
      uv0_q[0] <= tex_u_i;
      uv0_q[1] <= tex_v_i;
    end
  end

endmodule

### rtl/ttf_queue.sv
`timescale 1ns / 1ps
module ttf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ttf_pkg::tri_job_t  push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output ttf_pkg::tri_job_t  head_o
);
  import ttf_pkg::*;

  tri_job_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue pop while empty");

endmodule

### rtl/ttf_back.sv
`timescale 1ns / 1ps
module ttf_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            empty_i,
  input  ttf_pkg::tri_job_t               head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ttf_pkg::CW-1:0]   tangent_x_o,
  output logic signed [ttf_pkg::CW-1:0]   tangent_y_o,
  output logic signed [ttf_pkg::CW-1:0]   tangent_z_o,
  output logic signed [ttf_pkg::CW-1:0]   bitangent_x_o,
  output logic signed [ttf_pkg::CW-1:0]   bitangent_y_o,
  output logic signed [ttf_pkg::CW-1:0]   bitangent_z_o,
  output logic                            degenerate_o
);
  import ttf_pkg::*;

  back_state_e          state_q, state_d;
  tri_job_t             job_q;
  logic [2:0]           idx_q;
  logic [5:0]           cnt_q;
  logic signed [PW-1:0] prod1_q, prod2_q, prod;
  logic signed [DW-1:0] a1, b1, a2, b2, ma, mb;
  logic [SW-1:0]        det_mag_q;
  logic                 det_neg_q, num_neg_q;
  logic [NW-1:0]        n2_q;
  logic [RW-1:0]        rem_q, d2;
  logic [QW-1:0]        lo_q, q_q;
  logic                 ovf_q;
  logic [CW-1:0]        res_q [NCOMP];
  logic                 deg_q;
  logic                 out_valid_q;
  logic [CW-1:0]        out_q [NCOMP];
  logic                 out_deg_q;
  logic                 out_free;
  logic signed [SW-1:0] diff;
  logic [SW-1:0]        mag;
  logic [RW:0]          rem_sh;
  logic                 ge;
  logic                 rneg;
  logic [CW-1:0]        rval;
  logic [1:0]           comp;

  assign out_free = !out_valid_q || !out_stall_i;
  assign d2       = {det_mag_q, 1'b0};

  // operand selection for det, tangent and bitangent numerators
  always_comb begin
    comp = 2'd0;
    if (idx_q == 3'd0) begin
      a1 = job_q.du1; b1 = job_q.dv2; a2 = job_q.dv1; b2 = job_q.du2;
    end else if (idx_q <= 3'd3) begin
      comp = 2'(idx_q - 3'd1);
      a1 = job_q.e1[comp]; b1 = job_q.dv2; a2 = job_q.e2[comp]; b2 = job_q.dv1;
    end else begin
      comp = 2'(idx_q - 3'd4);
      a1 = job_q.e2[comp]; b1 = job_q.du1; a2 = job_q.e1[comp]; b2 = job_q.du2;
    end
    ma   = (state_q == B_MUL1) ? a1 : a2;
    mb   = (state_q == B_MUL1) ? b1 : b2;
    prod = ma * mb;
  end

  always_comb begin
    diff   = SW'(prod1_q) - SW'(prod2_q);
    mag    = diff[SW-1] ? SW'(-diff) : SW'(diff);
    rem_sh = {rem_q, lo_q[QW-1]};
    ge     = rem_sh >= {1'b0, d2};
    rneg   = (num_neg_q != det_neg_q) && (q_q != '0);
    if (rneg) begin
      if (ovf_q || q_q > {1'b0, 1'b1, {(CW-1){1'b0}}}) rval = {1'b1, {(CW-1){1'b0}}};
      else                                            rval = CW'(-q_q);
    end else begin
      if (ovf_q || q_q > {2'b0, {(CW-1){1'b1}}}) rval = {1'b0, {(CW-1){1'b1}}};
      else                                       rval = q_q[CW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = B_MUL1;
        end
      end
      B_MUL1: state_d = B_MUL2;
      B_MUL2: state_d = B_SUB;
      B_SUB: begin
        if (idx_q != 3'd0)   state_d = B_DIV0;
        else if (diff == '0) state_d = B_FIN;
        else                 state_d = B_MUL1;
      end
      B_DIV0: state_d = B_DIV;
      B_DIV:  if (cnt_q == 6'(QW - 1)) state_d = B_RES;
      B_RES:  state_d = (idx_q == 3'(NCOMP)) ? B_FIN : B_MUL1;
      B_FIN:  if (out_free) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_FIN && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)            out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        job_q <= head_i;
        idx_q <= 3'd0;
        deg_q <= 1'b0;
      end
      B_MUL1: prod1_q <= prod;
      B_MUL2: prod2_q <= prod;
      B_SUB: begin
        if (idx_q == 3'd0) begin
          det_mag_q <= mag;
          det_neg_q <= diff[SW-1];
          idx_q     <= 3'd1;
          if (diff == '0) begin
            deg_q <= 1'b1;
            for (int i = 0; i < NCOMP; i++) res_q[i] <= '0;
          end
        end else begin
          num_neg_q <= diff[SW-1];
          n2_q      <= {1'b0, mag, {(FRAC+1){1'b0}}} + NW'(det_mag_q);
        end
      end
      B_DIV0: begin
        ovf_q <= RW'(n2_q[NW-1:QW]) >= d2;
        rem_q <= RW'(n2_q[NW-1:QW]);
        lo_q  <= n2_q[QW-1:0];
        cnt_q <= 6'd0;
      end
      B_DIV: begin
        rem_q <= ge ? RW'(rem_sh - {1'b0, d2}) : rem_sh[RW-1:0];
        q_q   <= {q_q[QW-2:0], ge};
        lo_q  <= {lo_q[QW-2:0], 1'b0};
        cnt_q <= cnt_q + 6'd1;
      end
      B_RES: begin
        res_q[idx_q - 3'd1] <= rval;
        idx_q               <= idx_q + 3'd1;
      end
      B_FIN: begin
        if (out_free) begin
          for (int i = 0; i < NCOMP; i++) out_q[i] <= res_q[i];
          out_deg_q <= deg_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign tangent_x_o   = out_q[0];
  assign tangent_y_o   = out_q[1];
  assign tangent_z_o   = out_q[2];
  assign bitangent_x_o = out_q[3];
  assign bitangent_y_o = out_q[4];
  assign bitangent_z_o = out_q[5];
  assign degenerate_o  = out_deg_q;

  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> tangent_x_o == 0 && bitangent_z_o == 0)
    else $error("degenerate result with nonzero vector");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == B_IDLE) else $error("pop outside idle");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == B_DIV |-> cnt_q < 6'(QW)) else $error("divider overran");

endmodule

### rtl/triangle_tangent_frame.sv
`timescale 1ns / 1ps
// Takes triangle corners one per request and returns one tangent/bitangent pair per
// triangle in signed Q16.16, rounded half away from zero and saturated; a zero uv
// determinant gives zero vectors and degenerate high. The first two corners of a
// triangle are never stalled; the third is stalled while the two-entry triangle
// queue is full. The back end works one triangle at a time with one shared 33x33
// multiplier and a one-bit-per-cycle divider: it forms the uv determinant, then
// each of the six components in turn by two products, a subtraction and a division;
// a degenerate triangle skips the components and goes straight to handoff.
module triangle_tangent_frame (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [ttf_pkg::CW-1:0]   pos_x_i,
  input  logic signed [ttf_pkg::CW-1:0]   pos_y_i,
  input  logic signed [ttf_pkg::CW-1:0]   pos_z_i,
  input  logic signed [ttf_pkg::CW-1:0]   tex_u_i,
  input  logic signed [ttf_pkg::CW-1:0]   tex_v_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [ttf_pkg::CW-1:0]   tangent_x_o,
  output logic signed [ttf_pkg::CW-1:0]   tangent_y_o,
  output logic signed [ttf_pkg::CW-1:0]   tangent_z_o,
  output logic signed [ttf_pkg::CW-1:0]   bitangent_x_o,
  output logic signed [ttf_pkg::CW-1:0]   bitangent_y_o,
  output logic signed [ttf_pkg::CW-1:0]   bitangent_z_o,
  output logic                            degenerate_o
);
  import ttf_pkg::*;

  logic     push, pop, full, empty;
  tri_job_t push_data, head;

  ttf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .pos_x_i, .pos_y_i, .pos_z_i, .tex_u_i, .tex_v_i,
    .q_full_i(full), .push_o(push), .push_data_o(push_data)
  );

  ttf_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  ttf_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head), .pop_o(pop),
    .out_valid_o, .out_stall_i,
    .tangent_x_o, .tangent_y_o, .tangent_z_o,
    .bitangent_x_o, .bitangent_y_o, .bitangent_z_o, .degenerate_o
  );

endmodule

### tb/triangle_tangent_frame_checker.sv
`timescale 1ns / 1ps
module triangle_tangent_frame_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] tex_u_i,
  input  logic signed [31:0] tex_v_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] tangent_x_i,
  input  logic signed [31:0] tangent_y_i,
  input  logic signed [31:0] tangent_z_i,
  input  logic signed [31:0] bitangent_x_i,
  input  logic signed [31:0] bitangent_y_i,
  input  logic signed [31:0] bitangent_z_i,
  input  logic               degenerate_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    logic signed [31:0] comp [6];
    logic               degen;
  } frame_t;

  frame_t frame_q[$];
  logic signed [31:0] corner_pos [2][3];
  logic signed [31:0] corner_uv  [2][2];
  int corners_held;

  // round(num * 2^16 / den) half away from zero, saturated to 32 bits
  function automatic logic signed [31:0] fixed_quotient(logic signed [127:0] num,
                                                        logic signed [127:0] den);
    logic [127:0] nm, dm, q;
    logic         neg;
    nm  = num < 0 ? -num : num;
    dm  = den < 0 ? -den : den;
    q   = ((nm << 17) + dm) / (dm << 1);
    neg = ((num < 0) != (den < 0)) && q != 0;
    if (neg) begin
      if (q > 128'h8000_0000) return 32'sh8000_0000;
      return -$signed(q[31:0]);
    end
    if (q > 128'h7fff_ffff) return 32'sh7fff_ffff;
    return q[31:0];
  endfunction

  task automatic take_corner(logic signed [31:0] p [3], logic signed [31:0] uv [2]);
    logic signed [127:0] du1, dv1, du2, dv2, det, e1, e2;
    frame_t f;
    if (corners_held == 0 || corners_held == 1) begin
      corner_pos[corners_held] = p;
      corner_uv[corners_held]  = uv;
      corners_held++;
      return;
    end
    corners_held = 0;
    du1 = corner_uv[1][0] - corner_uv[0][0];
    dv1 = corner_uv[1][1] - corner_uv[0][1];
    du2 = uv[0] - corner_uv[0][0];
    dv2 = uv[1] - corner_uv[0][1];
    det = du1 * dv2 - dv1 * du2;
    f.degen = (det == 0);
    for (int i = 0; i < 3; i++) begin
      e1 = corner_pos[1][i] - corner_pos[0][i];
      e2 = p[i] - corner_pos[0][i];
      f.comp[i]     = f.degen ? '0 : fixed_quotient(e1 * dv2 - e2 * dv1, det);
      f.comp[3 + i] = f.degen ? '0 : fixed_quotient(e2 * du1 - e1 * du2, det);
    end
    frame_q = {frame_q, f};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic signed [31:0] p [3];
    logic signed [31:0] uv [2];
    logic signed [31:0] got [6];
    frame_t exp_f;
    bit bad;
    if (!rst_ni) begin
      corners_held = 0;
      fail_count_o = 0;
      frame_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        p  = '{pos_x_i, pos_y_i, pos_z_i};
        uv = '{tex_u_i, tex_v_i};
        take_corner(p, uv);
      end
      if (out_valid_i && !out_stall_i) begin
        got = '{tangent_x_i, tangent_y_i, tangent_z_i,
                bitangent_x_i, bitangent_y_i, bitangent_z_i};
        if (frame_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("unexpected result at %0t", $realtime);
        end else begin
          exp_f = frame_q.pop_front();
          bad = (exp_f.degen !== degenerate_i);
          for (int i = 0; i < 6; i++) if (exp_f.comp[i] !== got[i]) bad = 1;
          if (bad) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch at %0t: exp %p degen %b, got %p degen %b",
                       $realtime, exp_f.comp, exp_f.degen, got, degenerate_i);
          end
        end
      end
    end
    pending_o = frame_q.size();
  end

endmodule

### tb/triangle_tangent_frame_tb.sv
`timescale 1ns / 1ps
module triangle_tangent_frame_tb;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i, degenerate_o;
  logic signed [31:0] pos_x_i, pos_y_i, pos_z_i, tex_u_i, tex_v_i;
  logic signed [31:0] tangent_x_o, tangent_y_o, tangent_z_o;
  logic signed [31:0] bitangent_x_o, bitangent_y_o, bitangent_z_o;
  int fail_count, pending, idle_cycles;

  triangle_tangent_frame u_dut (.*);

  triangle_tangent_frame_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o),
    .pos_x_i, .pos_y_i, .pos_z_i, .tex_u_i, .tex_v_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .tangent_x_i(tangent_x_o), .tangent_y_i(tangent_y_o), .tangent_z_i(tangent_z_o),
    .bitangent_x_i(bitangent_x_o), .bitangent_y_i(bitangent_y_o),
    .bitangent_z_i(bitangent_z_o), .degenerate_i(degenerate_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 300);
  endfunction

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 16)) - 8;
    endcase
  endfunction

  // output stall: random gaps, with quiet stretches
  initial begin
    int n;
    out_stall_i = 0;
    @(posedge rst_ni);
    forever begin
      n = gap_len();
      if ($urandom_range(0, 9) == 0) n = 0;
      repeat (n) @(posedge clk_i) out_stall_i <= 1;
      @(posedge clk_i) out_stall_i <= 0;
      repeat ($urandom_range(0, 20)) @(posedge clk_i);
    end
  end

  task automatic send_corner(logic signed [31:0] px, py, pz, u, v);
    int n;
    n = ($urandom_range(0, 3) != 0) ? gap_len() : 0;
    if (n != 0) begin
      in_valid_i <= 0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1;
    pos_x_i <= px; pos_y_i <= py; pos_z_i <= pz; tex_u_i <= u; tex_v_i <= v;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random_triangle(int mode);
    int m;
    for (int c = 0; c < 3; c++) begin
      m = mode < 0 ? $urandom_range(0, 3) : mode;
      send_corner(rand_coord(m), rand_coord(m), rand_coord(m),
                  rand_coord(m), rand_coord(m));
    end
  endtask

  initial begin
    localparam logic signed [31:0] MAXV = 32'sh7fff_ffff, MINV = 32'sh8000_0000;
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    in_valid_i = 0;
    {pos_x_i, pos_y_i, pos_z_i, tex_u_i, tex_v_i} = '0;
    rst_ni = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // unit right triangle
    send_corner(0, 0, 0, 0, 0);
    send_corner(ONE, 0, 0, ONE, 0);
    send_corner(0, ONE, 0, 0, ONE);
    // degenerate uv
    send_corner(1, 2, 3, ONE, ONE);
    send_corner(4, 5, 6, ONE, ONE);
    send_corner(7, 8, 9, ONE, ONE);
    // extremes, saturation both ways
    send_corner(MINV, MINV, MINV, 0, 0);
    send_corner(MAXV, MAXV, MAXV, 1, 0);
    send_corner(MINV, MAXV, MINV, 0, 1);
    send_corner(MAXV, MINV, MAXV, MINV, MAXV);
    send_corner(MINV, MAXV, 0, MAXV, MINV);
    send_corner(0, 0, MINV, MINV, MINV);
    // half-unit quotient: det 2, numerator 1
    send_corner(0, 0, 0, 0, 0);
    send_corner(1, 1, 32'shffff_ffff, 2, 0);
    send_corner(0, 0, 0, 0, 1);
    for (int t = 0; t < 278; t++) send_random_triangle(t % 5 == 4 ? -1 : t % 4);
    in_valid_i <= 0;
    idle_cycles = 0;
    do begin
      @(posedge clk_i);
      idle_cycles++;
    end while (pending != 0 && idle_cycles < WATCHDOG_LIMIT);
    if (pending != 0) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      repeat (300) @(posedge clk_i);
      if (fail_count == 0) begin
        $display("ALL CHECKS PASSED");
      end else begin
        $display("CHECKS FAILED");
      end
      $finish;
    end
  end

  // watchdog on cycles with no accepted request or result
  initial begin
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

endmodule

### triangle_tangent_frame.f
rtl/ttf_pkg.sv
rtl/ttf_front.sv
rtl/ttf_queue.sv
rtl/ttf_back.sv
rtl/triangle_tangent_frame.sv
tb/triangle_tangent_frame_checker.sv
tb/triangle_tangent_frame_tb.sv
